// ===== rtl/core/five_level_priority_queue_assert.svh =====
// assertion macros used by the priority queue checker
`ifndef FIVE_LEVEL_PRIORITY_QUEUE_ASSERT_SVH
`define FIVE_LEVEL_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FPLQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FPLQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fplq_pkg.sv =====
// types and constants of the five level priority queue
package fplq_pkg;

	localparam int DEPTH   = 16;
	localparam int LEVELS  = 5;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int LVL_W   = $clog2(LEVELS);
	localparam int VAL_W   = 32;
	localparam int PRI_W   = 3;
	localparam int CAP_W   = 5;
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;

	// register byte addresses
	localparam logic [PADDR_W-1:0] REG_CAPACITY = 2'd0;

	typedef enum logic [1:0] {
		OP_ENQ      = 2'd0,
		OP_DEQ_OLD  = 2'd1,
		OP_DEQ_HIGH = 2'd2,
		OP_PEEK     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPRI = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_MOVE_RD,
		S_MOVE_WR,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [LVL_W-1:0]        level;
		logic signed [VAL_W-1:0] value;
	} entry_t;

endpackage

// ===== rtl/core/fplq_if.sv =====
// request and response channels of the priority queue
interface fplq_in_if;
	import fplq_pkg::*;

	logic                    valid;
	logic                    ready;
	op_t                     op;
	logic signed [VAL_W-1:0] value_in;
	logic [PRI_W-1:0]        priority_in;

	modport source (output valid, output op, output value_in, output priority_in,
		input ready);
	modport sink (input valid, input op, input value_in, input priority_in,
		output ready);
endinterface

interface fplq_out_if;
	import fplq_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value_out;
	status_t                 status;
	logic [CNT_W-1:0]        occupancy;

	modport source (output valid, output value_out, output status, output occupancy,
		input ready);
	modport sink (input valid, input value_out, input status, input occupancy,
		output ready);
endinterface

// ===== rtl/core/fplq_ram.sv =====
// generic single write port ram with registered read
module fplq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/five_level_priority_queue.sv =====
// five level priority queue: one word at a time, entries kept oldest first in one ram
// enqueue, full, bad priority and empty words pass from accept through the finish state to the output register
// dequeue oldest reads the head entry, then shifts each younger entry down in the ram
// dequeue/peek highest scans entries oldest first up to and including the match, and a dequeue
// then shifts the later entries down; next word accepted once the previous one has reached the output register
// reset clears counts, capacity and handshake state; ram contents stay undefined, no clearing pass
module five_level_priority_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	fplq_in_if.sink                       req,
	fplq_out_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fplq_pkg::PADDR_W-1:0]  paddr,
	input  logic [fplq_pkg::PDATA_W-1:0]  pwdata,
	output logic [fplq_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import fplq_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        lvl_cnt_q [LEVELS];
	logic [CAP_W-1:0]        cap_q;
	logic [ADDR_W-1:0]       idx_q;
	op_t                     op_q;
	logic [LVL_W-1:0]        target_q;
	logic signed [VAL_W-1:0] res_value_q;
	status_t                 res_status_q;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_value_q;
	status_t                 out_status_q;
	logic [CNT_W-1:0]        out_occ_q;

	logic             accept;
	logic             full;
	logic             bad_pri;
	logic             enq_ok;
	logic             hi_any;
	logic [LVL_W-1:0] hi_lvl;
	logic             match;
	logic             more_scan;
	logic             more_move;
	logic             out_free;
	logic             cfg_wr;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	entry_t            ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	entry_t            ram_rdata;

	fplq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && paddr == REG_CAPACITY;
	assign prdata = PDATA_W'(cap_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cap_q <= '0;
		else if (cfg_wr)
			cap_q <= pwdata[CAP_W-1:0];
	end

	// full check against limit, zero or oversize limit means the store depth
	always_comb begin
		if (cap_q == '0 || 32'(cap_q) > DEPTH)
			full = 32'(count_q) >= DEPTH;
		else
			full = count_q >= CNT_W'(cap_q);
	end

	assign bad_pri = 32'(req.priority_in) >= LEVELS;
	assign accept  = req.valid && req.ready;
	assign enq_ok  = accept && req.op == OP_ENQ && !full && !bad_pri;

	// highest non-empty level, upper levels win
	always_comb begin
		hi_any = 1'b0;
		hi_lvl = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (lvl_cnt_q[l] != '0) begin
				hi_any = 1'b1;
				hi_lvl = LVL_W'(l);
			end
		end
	end

	assign match     = (op_q == OP_DEQ_OLD) || (ram_rdata.level == target_q);
	assign more_scan = (CNT_W'(idx_q) + CNT_W'(1)) < count_q;
	assign more_move = (CNT_W'(idx_q) + CNT_W'(1)) < count_q;
	assign out_free  = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = count_q[ADDR_W-1:0];
		ram_wdata = '{level: LVL_W'(req.priority_in), value: req.value_in};
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				ram_we    = enq_ok;
				if (req.valid) begin
					if (req.op == OP_ENQ || count_q == '0)
						state_d = S_FIN;
					else if (req.op == OP_DEQ_OLD || hi_any)
						state_d = S_SCAN_RD;
					else
						state_d = S_FIN;
				end
			end
			S_SCAN_RD: begin
				ram_re  = 1'b1;
				state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (match) begin
					if (op_q != OP_PEEK && more_move)
						state_d = S_MOVE_RD;
					else
						state_d = S_FIN;
				end else if (more_scan) begin
					state_d = S_SCAN_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_MOVE_RD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q + ADDR_W'(1);
				state_d   = S_MOVE_WR;
			end
			S_MOVE_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = ram_rdata;
				// count already holds the reduced size here
				if ((CNT_W'(idx_q) + CNT_W'(2)) < (count_q + CNT_W'(1)))
					state_d = S_MOVE_RD;
				else
					state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int l = 0; l < LEVELS; l++)
				lvl_cnt_q[l] <= '0;
		end else if (enq_ok) begin
			count_q <= count_q + CNT_W'(1);
			lvl_cnt_q[LVL_W'(req.priority_in)] <=
				lvl_cnt_q[LVL_W'(req.priority_in)] + CNT_W'(1);
		end else if (state_q == S_SCAN_CHK && match && op_q != OP_PEEK) begin
			count_q <= count_q - CNT_W'(1);
			lvl_cnt_q[ram_rdata.level] <= lvl_cnt_q[ram_rdata.level] - CNT_W'(1);
		end
	end

	// per-word working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q        <= req.op;
					target_q    <= hi_lvl;
					idx_q       <= '0;
					res_value_q <= '0;
					if (req.op == OP_ENQ)
						res_status_q <= full ? ST_FULL : (bad_pri ? ST_BADPRI : ST_OK);
					else if (count_q == '0 || (req.op != OP_DEQ_OLD && !hi_any))
						res_status_q <= ST_EMPTY;
					else
						res_status_q <= ST_OK;
				end
			end
			S_SCAN_CHK: begin
				if (match)
					res_value_q <= ram_rdata.value;
				else if (more_scan)
					idx_q <= idx_q + ADDR_W'(1);
				else
					res_status_q <= ST_EMPTY;
			end
			S_MOVE_WR: begin
				idx_q <= idx_q + ADDR_W'(1);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_FIN && out_free)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
			out_occ_q    <= count_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.value_out = out_value_q;
	assign rsp.status    = out_status_q;
	assign rsp.occupancy = out_occ_q;
endmodule

// ===== rtl/core/fplq_checker.sv =====
// port level checks of the priority queue, bound to the top level
module fplq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic signed [31:0]            rsp_value_out,
	input logic [1:0]                    rsp_status,
	input logic [fplq_pkg::CNT_W-1:0]    rsp_occupancy
);
	import fplq_pkg::*;
`include "five_level_priority_queue_assert.svh"

	// a stalled result word holds
	`FPLQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value_out) && $stable(rsp_status) && $stable(rsp_occupancy), "response changed while stalled")

	// one word in flight at a time
	`FPLQ_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")

	`FPLQ_ASSERT_NOW(a_occ_bound, rsp_valid, 32'(rsp_occupancy) <= DEPTH, "occupancy beyond depth")

	`FPLQ_ASSERT_NOW(a_zero_on_error, rsp_valid && rsp_status != ST_OK, rsp_value_out == '0, "value on error response")

	`FPLQ_ASSERT_NOW(a_empty_occ, rsp_valid && rsp_status == ST_EMPTY, rsp_occupancy == '0, "empty reported with entries held")
endmodule

bind five_level_priority_queue fplq_checker u_fplq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_value_out(rsp.value_out),
	.rsp_status   (rsp.status),
	.rsp_occupancy(rsp.occupancy)
);
